// ===== sv/nearby_point_merge_table_unit_defines.svh =====
// Assertion macros for the nearby point merge table unit.
`ifndef NEARBY_POINT_MERGE_TABLE_UNIT_DEFINES_SVH
`define NEARBY_POINT_MERGE_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define NPM_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nearby point merge table: assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define NPM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nearby point merge table: assertion failed");

`else

`define NPM_ASSERT_IMPLIES(lbl, ante, cons)
`define NPM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/npm_pkg.sv =====
// Package with types, constants and codes of the nearby point merge table.
`timescale 1ns / 1ps
`default_nettype none

package npm_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int COORD_W     = 24;
   localparam int TOL_W       = 23;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int TOTAL_W     = IDX_W + 1;
   localparam int SQ_W        = 2 * TOL_W;
   localparam int SUM_W       = SQ_W + 2;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(10);

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_READ   = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } entry_type;

   typedef struct packed {
      cmd_type          cmd;
      coord_type        x_coord;
      coord_type        y_coord;
      coord_type        z_coord;
      logic [IDX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]   match_index;
      logic               is_new;
      logic               overflow;
      logic [TOTAL_W-1:0] entry_total;
      coord_type          out_x;
      coord_type          out_y;
      coord_type          out_z;
   } rsp_type;

   // Control into the distance pipeline.
   typedef struct packed {
      logic             valid;
      logic             flush;
      logic [IDX_W-1:0] idx;
   } scan_ctl_type;

   // Status out of the distance pipeline.
   typedef struct packed {
      logic             hit;
      logic             busy;
      logic [IDX_W-1:0] idx;
   } scan_stat_type;

endpackage

`default_nettype wire

// ===== sv/npm_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
`timescale 1ns / 1ps
`default_nettype none

module npm_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 72
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/npm_dist_pipe.sv =====
// Two-stage distance pipeline: absolute differences, then squares and the tolerance test.
`timescale 1ns / 1ps
`default_nettype none

module npm_dist_pipe (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire npm_pkg::scan_ctl_type       ctl,
   input  wire npm_pkg::entry_type          entry,
   input  wire npm_pkg::entry_type          point,
   input  wire logic [npm_pkg::TOL_W-1:0]   tol,
   input  wire logic [npm_pkg::SQ_W-1:0]    tol_sq,
   output      npm_pkg::scan_stat_type      stat,
   output      npm_pkg::entry_type          avg
);
   import npm_pkg::*;

   function automatic logic [COORD_W-1:0] abs_diff(input coord_type a, input coord_type b);
      logic [COORD_W:0] d;
      logic [COORD_W:0] m;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      m = d[COORD_W] ? (~d + 1'b1) : d;
      return m[COORD_W-1:0];
   endfunction

   // Floor of the halved sum; the 25-bit sum shifted right keeps the sign.
   function automatic coord_type half_sum(input coord_type a, input coord_type b);
      logic [COORD_W:0] s;
      s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
      return s[COORD_W:1];
   endfunction

   // First stage
   logic               a_valid_ff;
   logic [IDX_W-1:0]   a_idx_ff;
   logic [COORD_W-1:0] a_dx_ff, a_dy_ff, a_dz_ff;
   entry_type          a_avg_ff;

   // Second stage
   logic               b_valid_ff;
   logic [IDX_W-1:0]   b_idx_ff;
   logic               b_near_ff;
   logic [SQ_W-1:0]    b_sqx_ff, b_sqy_ff, b_sqz_ff;
   entry_type          b_avg_ff;

   logic [COORD_W-1:0] tol_ext;
   logic               near_in;
   logic [SUM_W-1:0]   sq_sum;

   assign tol_ext = COORD_W'(tol);
   assign near_in = (a_dx_ff <= tol_ext) && (a_dy_ff <= tol_ext) && (a_dz_ff <= tol_ext);
   assign sq_sum  = SUM_W'(b_sqx_ff) + SUM_W'(b_sqy_ff) + SUM_W'(b_sqz_ff);

   always_ff @(posedge clock) begin
      if (reset || ctl.flush) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= ctl.valid;
         b_valid_ff <= a_valid_ff;
      end
      a_idx_ff   <= ctl.idx;
      a_dx_ff    <= abs_diff(entry.x, point.x);
      a_dy_ff    <= abs_diff(entry.y, point.y);
      a_dz_ff    <= abs_diff(entry.z, point.z);
      a_avg_ff.x <= half_sum(entry.x, point.x);
      a_avg_ff.y <= half_sum(entry.y, point.y);
      a_avg_ff.z <= half_sum(entry.z, point.z);
      b_idx_ff   <= a_idx_ff;
      b_near_ff  <= near_in;
      // Only the low bits matter when the difference is within tolerance.
      b_sqx_ff   <= SQ_W'(a_dx_ff[TOL_W-1:0]) * SQ_W'(a_dx_ff[TOL_W-1:0]);
      b_sqy_ff   <= SQ_W'(a_dy_ff[TOL_W-1:0]) * SQ_W'(a_dy_ff[TOL_W-1:0]);
      b_sqz_ff   <= SQ_W'(a_dz_ff[TOL_W-1:0]) * SQ_W'(a_dz_ff[TOL_W-1:0]);
      b_avg_ff   <= a_avg_ff;
   end

   always_comb begin
      stat.hit  = b_valid_ff && b_near_ff && (sq_sum <= SUM_W'(tol_sq));
      stat.busy = a_valid_ff || b_valid_ff;
      stat.idx  = b_idx_ff;
      avg       = b_avg_ff;
   end

endmodule

`default_nettype wire

// ===== sv/nearby_point_merge_table_unit.sv =====
// Top level of the nearby point merge table: control, entry count and result register.
//
//   Channel  Ports                        Direction  Beat
//   req      req_valid/req_ready/req_*    in         one command with point or index
//   rsp      rsp_valid/rsp_ready/rsp_*    out        one result per command
//   csr      csr_wr_en/csr_wr_data        in         merge tolerance write
//
// An insert reads the table one entry per cycle through the RAM read port and scans
// every stored entry, stopping early when an entry matches; an empty table is not read.
// A read, clear or no-operation needs no scan; any command may wait on rsp_ready.
// Reset clears the entry count but not the table RAM, which is not swept.
// The result register lets the next command be accepted while a result waits.
`timescale 1ns / 1ps
`default_nettype none
`include "nearby_point_merge_table_unit_defines.svh"

module nearby_point_merge_table_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire npm_pkg::req_type           req_payload,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      npm_pkg::rsp_type           rsp_payload,
   input  wire logic                       csr_wr_en,
   input  wire logic [npm_pkg::TOL_W-1:0]  csr_wr_data
);
   import npm_pkg::*;

   state_type          state_ff, state_in;
   logic [TOTAL_W-1:0] count_ff, count_in;
   logic [TOTAL_W-1:0] iss_ff, iss_in;
   logic               rd_valid_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [TOL_W-1:0]   tol_ff;
   logic [SQ_W-1:0]    tol_sq_ff, tol_sq_in;
   req_type            pt_ff;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic               accept;
   logic               issue;
   logic               scan_done;
   logic               table_full;
   logic               append_en;
   logic               rsp_load;
   logic [IDX_W-1:0]   rd_addr;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   entry_type          mem_wdata;
   entry_type          mem_rdata;
   entry_type          point;
   entry_type          avg;
   scan_ctl_type       ctl;
   scan_stat_type      stat;

   npm_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH ($bits(entry_type))
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (rd_addr),
      .rd_data (mem_rdata)
   );

   npm_dist_pipe u_dist (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .entry  (mem_rdata),
      .point  (point),
      .tol    (tol_ff),
      .tol_sq (tol_sq_ff),
      .stat   (stat),
      .avg    (avg)
   );

   assign point.x    = pt_ff.x_coord;
   assign point.y    = pt_ff.y_coord;
   assign point.z    = pt_ff.z_coord;
   assign table_full = (count_ff == TOTAL_W'(TABLE_DEPTH));
   assign tol_sq_in  = SQ_W'(tol_ff) * SQ_W'(tol_ff);
   assign accept     = req_valid && req_ready;

   // The scan is over once every stored entry has left the pipeline without a hit.
   assign scan_done  = (state_ff == ST_SCAN) && (iss_ff == count_ff) &&
                       !rd_valid_ff && !stat.busy;
   assign append_en  = scan_done && !table_full;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_payload.cmd)
                  CMD_INSERT: state_in = ST_SCAN;
                  CMD_READ:   state_in = ST_READ;
                  CMD_CLEAR,
                  CMD_NOP:    state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            if (stat.hit || scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Outputs and datapath control
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rd_addr   = (state_ff == ST_IDLE) ? req_payload.read_index : iss_ff[IDX_W-1:0];
      issue     = (state_ff == ST_SCAN) && (iss_ff < count_ff) && !stat.hit;
      iss_in    = (state_ff == ST_IDLE) ? '0 : (issue ? iss_ff + 1'b1 : iss_ff);
      rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

      ctl.valid = rd_valid_ff;
      ctl.flush = stat.hit;
      ctl.idx   = rd_idx_ff;

      mem_we    = 1'b0;
      mem_waddr = stat.idx;
      mem_wdata = avg;
      count_in  = count_ff;
      res_in    = res_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_payload.cmd == CMD_CLEAR) begin
               count_in = '0;
               res_in   = '0;
            end else if (accept && req_payload.cmd == CMD_NOP) begin
               res_in             = '0;
               res_in.entry_total = count_ff;
            end
         end
         ST_SCAN: begin
            if (stat.hit) begin
               mem_we             = 1'b1;
               res_in             = '0;
               res_in.match_index = stat.idx;
               res_in.entry_total = count_ff;
            end else if (scan_done) begin
               res_in = '0;
               if (append_en) begin
                  mem_we             = 1'b1;
                  mem_waddr          = count_ff[IDX_W-1:0];
                  mem_wdata          = point;
                  count_in           = count_ff + 1'b1;
                  res_in.match_index = count_ff[IDX_W-1:0];
                  res_in.is_new      = 1'b1;
                  res_in.entry_total = count_ff + 1'b1;
               end else begin
                  res_in.overflow    = 1'b1;
                  res_in.entry_total = count_ff;
               end
            end
         end
         ST_READ: begin
            res_in             = '0;
            res_in.entry_total = count_ff;
            if (TOTAL_W'(pt_ff.read_index) < count_ff) begin
               res_in.out_x = mem_rdata.x;
               res_in.out_y = mem_rdata.y;
               res_in.out_z = mem_rdata.z;
            end
         end
         ST_DONE: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         iss_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         tol_ff       <= TOL_RESET;
         tol_sq_ff    <= SQ_W'(TOL_RESET) * SQ_W'(TOL_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         iss_ff      <= iss_in;
         rd_valid_ff <= issue;
         tol_sq_ff   <= tol_sq_in;
         if (csr_wr_en) begin
            tol_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pt_ff <= req_payload;
      end
      rd_idx_ff <= iss_ff[IDX_W-1:0];
      res_ff    <= res_in;
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The table is only written at the end of an insert scan.
   `NPM_ASSERT_IMPLIES(a_write_in_scan, mem_we, state_ff == ST_SCAN)
   // A merge always lands on an entry that is already stored.
   `NPM_ASSERT_IMPLIES(a_hit_in_range, stat.hit, TOTAL_W'(stat.idx) < count_ff)
   // The issue pointer never runs past the stored entries.
   `NPM_ASSERT_IMPLIES(a_issue_bound, state_ff == ST_SCAN, iss_ff <= count_ff)
   // An append grows the count by exactly one.
   `NPM_ASSERT_NEXT(a_append_count, append_en, count_ff == $past(count_ff) + 1'b1)

endmodule

`default_nettype wire
